/* hw/rtl/rpr_pkg.sv */
`default_nettype none

package rpr_pkg;

  localparam int MaxPairs  = 64;
  localparam int PairW     = 7;
  localparam int EffPairs  = (MaxPairs < 127) ? MaxPairs : 127;
  localparam int CntW      = (EffPairs > 1) ? $clog2(2 * EffPairs) : 1;
  localparam int AddrW     = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int ValW      = 16;
  localparam int IdxW      = 6;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;
  localparam int RoundBias = 8192;
  localparam int FracShift = 14;

  typedef enum logic [0:0] {
    RegPairsPerRow = 1'b0,
    RegUnused      = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] x_value;
    logic signed [ValW-1:0] cos_value;
    logic signed [ValW-1:0] sin_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_low;
    logic signed [ValW-1:0] out_high;
    logic [IdxW-1:0]        pair_index;
    logic                   row_last;
  } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/rpr_ram.sv */
`default_nettype none

module rpr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire                                   clk_i,
  input  wire                                   we_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire [Width-1:0]                       wdata_i,
  input  wire                                   re_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rotary_position_rotate.sv */
// Rotary position embedding, half-split form, on a stream of Q8.8 elements.
// Input channel (in_valid_i/in_ready_o/in_data_i): one element of a head row per
// transaction, with the Q1.14 cosine and sine of its pair. A row is 2*P elements,
// P set by the pairs_per_row register (0 acts as 1, above MAX_PAIRS as MAX_PAIRS).
// The first P elements are written to the first-half RAM and give no result.
// Element P+i reads entry i and is rotated with it; one output transaction
// carries both rotated values, the pair index and a last-pair flag.
// Throughput: one input transaction per cycle while the receiver takes results.
// Stages: RAM read, multiplier, then round/saturate into the output register.
// When the receiver stalls, the output register holds its result and the two
// stages behind it keep filling; input ready drops only when all are full.
// Writing pairs_per_row (APB, byte address 0) restarts the row count.
// Reset: pairs_per_row is 64, the row count is zero, the pipeline is empty;
// the RAM contents are undefined and are always written before they are read.
`default_nettype none

module rotary_position_rotate (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire rpr_pkg::in_item_t     in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output rpr_pkg::out_item_t         out_data_o,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [rpr_pkg::PaddrW-1:0]  paddr,
  input  wire [rpr_pkg::PdataW-1:0]  pwdata,
  output logic [rpr_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import rpr_pkg::*;

  function automatic logic signed [ValW-1:0] round_sat(input logic signed [2*ValW:0] acc);
    logic signed [2*ValW+1:0] biased;
    logic signed [2*ValW+1:0] q;
    biased = {acc[2*ValW], acc} + (2*ValW+2)'(RoundBias);
    q      = biased >>> FracShift;
    if (q > (2*ValW+2)'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (q < -(2*ValW+2)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[ValW-1:0];
    end
  endfunction

  logic [PairW-1:0] ppr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready && (cfg_idx == RegPairsPerRow);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegPairsPerRow: prdata = PdataW'(ppr_q);
      default:        prdata = '0;
    endcase
  end

  logic [PairW-1:0] p_act;
  logic [PairW:0]   two_p;
  logic [PairW:0]   cnt_norm, pair_i, cnt_next;
  logic             second_half, pair_last, in_acc;

  always_comb begin
    if (ppr_q == '0) begin
      p_act = PairW'(1);
    end else if (ppr_q > PairW'(EffPairs)) begin
      p_act = PairW'(EffPairs);
    end else begin
      p_act = ppr_q;
    end
    two_p       = {p_act, 1'b0};
    cnt_norm    = ((PairW+1)'(cnt_q) >= two_p) ? '0 : (PairW+1)'(cnt_q);
    second_half = cnt_norm >= {1'b0, p_act};
    pair_i      = cnt_norm - {1'b0, p_act};
    pair_last   = pair_i == ({1'b0, p_act} - (PairW+1)'(1));
    cnt_next    = cnt_norm + (PairW+1)'(1);
    cnt_d       = (cnt_next >= two_p) ? '0 : CntW'(cnt_next);
  end

  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_free, s1_free;

  assign out_free   = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= PairW'(64);
      cnt_q <= '0;
    end else if (cfg_we) begin
      ppr_q <= pwdata[PairW-1:0];
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= cnt_d;
    end
  end

  logic [ValW-1:0] x0_rdata;

  rpr_ram #(
    .Width (ValW),
    .Depth (MaxPairs)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !second_half),
    .waddr_i (AddrW'(cnt_norm)),
    .wdata_i (in_data_i.x_value),
    .re_i    (in_acc && second_half),
    .raddr_i (AddrW'(pair_i)),
    .rdata_o (x0_rdata)
  );

  logic signed [ValW-1:0] s1_x1_q, s1_cos_q, s1_sin_q;
  logic [IdxW-1:0]        s1_idx_q, s2_idx_q;
  logic                   s1_last_q, s2_last_q;
  logic signed [2*ValW-1:0] lc_q, ls_q, hs_q, hc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_acc && second_half;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && second_half) begin
      s1_x1_q   <= in_data_i.x_value;
      s1_cos_q  <= in_data_i.cos_value;
      s1_sin_q  <= in_data_i.sin_value;
      s1_idx_q  <= IdxW'(pair_i);
      s1_last_q <= pair_last;
    end
    if (s1_v_q && s2_free) begin
      lc_q      <= $signed(x0_rdata) * s1_cos_q;
      ls_q      <= s1_x1_q * s1_sin_q;
      hs_q      <= $signed(x0_rdata) * s1_sin_q;
      hc_q      <= s1_x1_q * s1_cos_q;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
    end
    if (s2_v_q && out_free) begin
      out_data_o.out_low    <= round_sat((2*ValW+1)'(lc_q) - (2*ValW+1)'(ls_q));
      out_data_o.out_high   <= round_sat((2*ValW+1)'(hs_q) + (2*ValW+1)'(hc_q));
      out_data_o.pair_index <= s2_idx_q;
      out_data_o.row_last   <= s2_last_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

/* hw/rtl/rpr_checker.sv */
`default_nettype none

module rpr_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire rpr_pkg::out_item_t    out_data_i,
  input wire                        psel,
  input wire                        penable,
  input wire                        pwrite,
  input wire [rpr_pkg::PaddrW-1:0]  paddr,
  input wire                        pready
);
  import rpr_pkg::*;

  logic            out_acc, cfg_acc;
  logic            seen_q, last_q;
  logic [IdxW-1:0] idx_q;

  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_acc = psel && penable && pwrite && pready &&
                   (reg_idx_e'(paddr[2]) == RegPairsPerRow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= 1'b0;
      idx_q  <= '0;
    end else if (cfg_acc) begin
      seen_q <= 1'b0;
    end else if (out_acc) begin
      seen_q <= 1'b1;
      last_q <= out_data_i.row_last;
      idx_q  <= out_data_i.pair_index;
    end
  end

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_pair_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && !last_q |-> out_data_i.pair_index == idx_q + IdxW'(1))
    else $error("pair index skipped within a row");

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (!seen_q || last_q) |-> out_data_i.pair_index == '0)
    else $error("row did not start at pair zero");

endmodule

bind rotary_position_rotate rpr_checker u_rpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pready      (pready)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpr_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned SegmentItems = 80;

  typedef enum logic {
    RowItem,
    RowWrite
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    reg_idx_e          reg_idx;
    logic [PdataW-1:0] wdata;
    in_item_t          element;
    bit                typed;
    out_item_t         result;
  } step_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [PdataW-1:0] pwdata      = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  logic [PairW-1:0]       pairs_setting = 7'd64;
  int unsigned            row_pos       = 0;
  logic signed [ValW-1:0] first_half [MaxPairs];
  out_item_t              pending_pairs [$];
  step_row_t              directed_steps [$];

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int          mismatches    = 0;

  rotary_position_rotate uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned live_pairs();
    if (pairs_setting == 0) return 1;
    if (pairs_setting > MaxPairs) return MaxPairs;
    return pairs_setting;
  endfunction

  function automatic logic [ValW-1:0] round_q88(longint acc);
    longint q;
    q = (acc + RoundBias) >>> FracShift;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[ValW-1:0];
  endfunction

  function automatic bit rotate_element(input in_item_t el, output out_item_t res);
    int unsigned p;
    int unsigned i;
    longint x0, x1, c, s;
    bit produced;
    p = live_pairs();
    res = '0;
    produced = 1'b0;
    if (row_pos >= 2 * p) row_pos = 0;
    if (row_pos < p) begin
      first_half[row_pos] = el.x_value;
      row_pos++;
    end else begin
      i  = row_pos - p;
      x0 = first_half[i];
      x1 = $signed(el.x_value);
      c  = $signed(el.cos_value);
      s  = $signed(el.sin_value);
      res.out_low    = round_q88(x0 * c - x1 * s);
      res.out_high   = round_q88(x0 * s + x1 * c);
      res.pair_index = i[IdxW-1:0];
      res.row_last   = (i == p - 1);
      row_pos++;
      if (row_pos >= 2 * p) row_pos = 0;
      produced = 1'b1;
    end
    return produced;
  endfunction

  function automatic logic [ValW-1:0] random_trig();
    int v;
    case ($urandom_range(7))
      0: begin
        v = 16384;
      end
      1: begin
        v = -16384;
      end
      default: begin
        v = int'($urandom_range(32768)) - 16384;
      end
    endcase
    return v[ValW-1:0];
  endfunction

  function automatic in_item_t random_element();
    in_item_t e;
    case ($urandom_range(7))
      0: begin
        e.x_value = 16'sh7fff;
      end
      1: begin
        e.x_value = 16'sh8000;
      end
      default: begin
        e.x_value = ValW'($urandom_range(65535));
      end
    endcase
    e.cos_value = random_trig();
    e.sin_value = random_trig();
    return e;
  endfunction

  function automatic step_row_t element_row(int x, int c, int s);
    step_row_t r;
    r.kind              = RowItem;
    r.reg_idx           = RegPairsPerRow;
    r.wdata             = '0;
    r.element.x_value   = x[ValW-1:0];
    r.element.cos_value = c[ValW-1:0];
    r.element.sin_value = s[ValW-1:0];
    r.typed             = 1'b0;
    r.result            = '0;
    return r;
  endfunction

  function automatic step_row_t known_row(int x, int c, int s, int lo, int hi, int idx,
                                          bit last);
    step_row_t r;
    r                   = element_row(x, c, s);
    r.typed             = 1'b1;
    r.result.out_low    = lo[ValW-1:0];
    r.result.out_high   = hi[ValW-1:0];
    r.result.pair_index = idx[IdxW-1:0];
    r.result.row_last   = last;
    return r;
  endfunction

  function automatic step_row_t write_row(reg_idx_e idx, int value);
    step_row_t r;
    r         = element_row(0, 0, 0);
    r.kind    = RowWrite;
    r.reg_idx = idx;
    r.wdata   = value;
    return r;
  endfunction

  task automatic send_element(input in_item_t el, input bit typed, input out_item_t typed_result);
    out_item_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= random_element();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= el;
    do @(posedge clk_i); while (!in_ready_o);
    if (rotate_element(el, predicted)) begin
      pending_pairs.push_back(typed ? typed_result : predicted);
    end
  endtask

  task automatic stop_input();
    @(negedge clk_i) in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [PdataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegPairsPerRow) begin
      pairs_setting = value[PairW-1:0];
      row_pos       = 0;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("out_low", $signed(want.out_low), $signed(out_data_o.out_low));
        check_field("out_high", $signed(want.out_high), $signed(out_data_o.out_high));
        check_field("pair_index", want.pair_index, out_data_o.pair_index);
        check_field("row_last", want.row_last, out_data_o.row_last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** rotary_position_rotate: FAILED **");
      $finish;
    end
  end

  initial begin
    step_row_t row;
    directed_steps.push_back(write_row(RegPairsPerRow, 1));
    directed_steps.push_back(element_row(32767, 0, 0));
    directed_steps.push_back(known_row(32767, 16384, 0, 32767, 32767, 0, 1'b1));
    directed_steps.push_back(element_row(-32768, 0, 0));
    directed_steps.push_back(known_row(-32768, 16384, 16384, 0, -32768, 0, 1'b1));
    directed_steps.push_back(element_row(32767, -16384, 16384));
    directed_steps.push_back(known_row(-32768, -16384, -16384, -32768, 1, 0, 1'b1));
    // ties round toward plus infinity
    directed_steps.push_back(element_row(1, 0, 0));
    directed_steps.push_back(known_row(0, 8192, 0, 1, 0, 0, 1'b1));
    directed_steps.push_back(element_row(-1, 0, 0));
    directed_steps.push_back(known_row(0, 8192, 0, 0, 0, 0, 1'b1));
    // zero pairs behaves as one pair
    directed_steps.push_back(write_row(RegPairsPerRow, 0));
    directed_steps.push_back(element_row(5, 0, 0));
    directed_steps.push_back(known_row(7, 16384, 0, 5, 7, 0, 1'b1));
    // write to an unused index must not restart the row
    directed_steps.push_back(write_row(RegPairsPerRow, 3));
    directed_steps.push_back(element_row(256, 0, 0));
    directed_steps.push_back(element_row(-512, 0, 0));
    directed_steps.push_back(write_row(RegUnused, 1));
    directed_steps.push_back(element_row(1000, 0, 0));
    directed_steps.push_back(element_row(300, 11585, 11585));
    directed_steps.push_back(element_row(-700, 16384, -16384));
    directed_steps.push_back(element_row(32767, -16384, 16384));
    // pairs_per_row write in mid-row restarts it
    directed_steps.push_back(element_row(1234, 0, 0));
    directed_steps.push_back(element_row(-4321, 0, 0));
    directed_steps.push_back(write_row(RegPairsPerRow, 3));
    directed_steps.push_back(element_row(-32768, 0, 0));
    directed_steps.push_back(element_row(32767, 0, 0));
    directed_steps.push_back(element_row(-77, 0, 0));
    directed_steps.push_back(element_row(32767, 16384, 16384));
    directed_steps.push_back(element_row(-32768, 9000, -15000));
    directed_steps.push_back(element_row(123, -16384, 0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed_steps[n]) begin
      row = directed_steps[n];
      if (row.kind == RowWrite) begin
        stop_input();
        wait_drained();
        write_reg(row.reg_idx, row.wdata);
      end else begin
        send_element(row.element, row.typed, row.result);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 61;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 61;
        end
        default: begin
          in_idle_pct   = 27;
          out_stall_pct = 27;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        stop_input();
        wait_drained();
        case (seg)
          0: begin
            write_reg(RegPairsPerRow, $urandom_range(16, 2));
          end
          1: begin
            write_reg(RegPairsPerRow, 1);
          end
          2: begin
            write_reg(RegPairsPerRow, MaxPairs);
          end
          3: begin
            write_reg(RegPairsPerRow, 0);
          end
          4: begin
            write_reg(RegPairsPerRow, $urandom_range(16, 2));
          end
          default: begin
            write_reg(RegPairsPerRow, (ph == 0) ? 127 : $urandom_range(127, 65));
          end
        endcase
        for (int n = 0; n < SegmentItems; n++) begin
          if (seg == 4 && n == SegmentItems / 2) begin
            stop_input();
            wait_drained();
            write_reg(RegUnused, $urandom());
          end
          send_element(random_element(), 1'b0, '0);
        end
      end
    end

    stop_input();
    wait_drained();
    if (mismatches == 0) begin
      $display("** rotary_position_rotate: PASSED **");
    end else begin
      $display("** rotary_position_rotate: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
